>>> rtl/core/pvs_pkg.sv
`timescale 1ns / 1ps
// pvs_pkg: shared constants, types and state codes of the segmenter
// no dependencies

package pvs_pkg;

   // default sizing
   localparam int DEF_VOCAB       = 64;
   localparam int DEF_MAX_LEN     = 64;
   localparam int DEF_WEIGHT_BITS = 24;
   localparam int DEF_SCORE_BITS  = 32;

   // fixed field widths
   localparam int TOK_W = 6;

   // register indexes on the csr port
   localparam logic CSR_VOCAB = 1'b0;
   localparam logic CSR_TRAIN = 1'b1;

   // reset value of the vocabulary register
   localparam logic [6:0] VOCAB_RESET = 7'd64;

   // index of the last n-gram feature template; five features per token
   localparam logic [2:0] FEAT_LAST = 3'd4;

   // token window around the current position
   typedef struct packed {
      logic [TOK_W-1:0] prev;
      logic [TOK_W-1:0] cur;
      logic [TOK_W-1:0] nxt;
      logic             has_prev;
      logic             has_next;
   } pvs_win_type;

   // sequencer states
   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PRIME,
      ST_PRIME_W,
      ST_FETCH,
      ST_FETCH_W,
      ST_WRD,
      ST_WLAST,
      ST_COMB,
      ST_BT_RD,
      ST_BT_WR,
      ST_EM_RD,
      ST_EM_LD,
      ST_EM_HOLD,
      ST_TR_CHK,
      ST_TR_RD,
      ST_TR_WR
   } pvs_state_type;

endpackage

>>> rtl/core/pvs_ram.sv
`timescale 1ns / 1ps
// pvs_ram: generic single write port, single read port ram with registered read
// no dependencies

module pvs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> rtl/core/pvs_feat.sv
`timescale 1ns / 1ps
// pvs_feat: n-gram feature index of the current token for one selected feature
// depends on pvs_pkg

module pvs_feat import pvs_pkg::*; #(
   parameter int VOCAB = DEF_VOCAB
) (
   input  pvs_win_type                                          win,
   input  logic [$clog2(VOCAB+1)-1:0]                           vocab,
   input  logic [2:0]                                           sel,
   output logic [$clog2(2*VOCAB*VOCAB+3*VOCAB+1)-1:0]           feat
);

   localparam int FB = $clog2(2*VOCAB*VOCAB+3*VOCAB+1);

   logic [FB-1:0] vv, pv, cv, nv, base3;

   // ids outside the dictionary count as unknown
   always_comb begin
      vv = FB'(vocab);
      pv = (win.has_prev && (9'(win.prev) < 9'(vocab))) ? FB'(win.prev) : '0;
      cv = (9'(win.cur) < 9'(vocab)) ? FB'(win.cur) : '0;
      nv = (win.has_next && (9'(win.nxt) < 9'(vocab))) ? FB'(win.nxt) : '0;
      base3 = vv + vv + vv + FB'(1);
   end

   // pick one of the five templates
   always_comb begin
      case (sel)
         3'd0:    feat = pv + FB'(1);
         3'd1:    feat = cv + vv + FB'(1);
         3'd2:    feat = nv + vv + vv + FB'(1);
         3'd3:    feat = FB'(pv * vv) + cv + base3;
         3'd4:    feat = FB'(cv * vv) + nv + FB'(vv * vv) + base3;
         default: feat = '0;
      endcase
   end

endmodule

>>> rtl/core/perceptron_viterbi_segmenter.sv
`timescale 1ns / 1ps
// perceptron_viterbi_segmenter: two-state viterbi word segmenter with perceptron update
// depends on pvs_pkg, pvs_ram, pvs_feat
//
// Usage: tokens of a sentence arrive as req beats (token id, gold tag, end marker).
// Tokens are buffered; beats after MAX_LEN are dropped and flag overflow.
// A beat without the end marker leaves req_ready high. On the end-marked beat the
// block decodes: per token a window fetch (ST_FETCH, ST_FETCH_W), 20 weight reads
// through the single weight-ram read port, and the compares of ST_COMB for each tag.
// A backtrace follows, then one rsp beat per token in order. In train mode the
// update then walks the sentence, with a read-modify-write of ten weights at each
// mismatching token. req_ready is low for the whole of this.
// A stalled rsp receiver holds the sequencer in place; nothing is lost.
// After reset a clearing pass writes zero to every weight entry, while req_ready
// stays low; the csr port works.

module perceptron_viterbi_segmenter import pvs_pkg::*; #(
   parameter int VOCAB       = DEF_VOCAB,
   parameter int MAX_LEN     = DEF_MAX_LEN,
   parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
   parameter int SCORE_BITS  = DEF_SCORE_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [5:0]  req_token_id,
   input  logic        req_gold_boundary,
   input  logic        req_end_of_sentence,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_boundary_tag,
   output logic [5:0]  rsp_position,
   output logic        rsp_last_of_run,
   output logic        rsp_overflow,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int FB  = $clog2(2*VOCAB*VOCAB+3*VOCAB+1);
   localparam int WA  = FB + 2;
   localparam int VB  = $clog2(VOCAB+1);
   localparam int LW  = $clog2(MAX_LEN+1);
   localparam int AW  = $clog2(MAX_LEN);
   localparam int AB  = WEIGHT_BITS + 3;
   localparam int SW  = ((SCORE_BITS > AB) ? SCORE_BITS : AB) + 1;
   localparam int WW  = WEIGHT_BITS + 1;

   localparam logic signed [SW-1:0] SMAX = {{(SW-SCORE_BITS+1){1'b0}}, {(SCORE_BITS-1){1'b1}}};
   localparam logic signed [SW-1:0] SMIN = {{(SW-SCORE_BITS+1){1'b1}}, {(SCORE_BITS-1){1'b0}}};
   localparam logic signed [WW-1:0] WMAX = {2'b00, {(WEIGHT_BITS-1){1'b1}}};
   localparam logic signed [WW-1:0] WMIN = {2'b11, {(WEIGHT_BITS-1){1'b0}}};

   function automatic logic signed [SCORE_BITS-1:0] sat_score(input logic signed [SW-1:0] x);
      logic signed [SW-1:0] y;
      y = x;
      if (x > SMAX) y = SMAX;
      if (x < SMIN) y = SMIN;
      return y[SCORE_BITS-1:0];
   endfunction

   // registers
   pvs_state_type state_ff, state_in;
   logic [LW-1:0] j_ff, j_in, len_ff, len_in;
   logic ovf_ff, ovf_in, phase_ff, phase_in;
   logic [TOK_W-1:0] wprev_ff, wprev_in, wcur_ff, wcur_in, wnxt_ff, wnxt_in;
   logic gcur_ff, gcur_in, gnxt_ff, gnxt_in, p_ff, p_in;
   logic gprev_ff, gprev_in, pprev_ff, pprev_in;
   logic [1:0] t_ff, t_in, pt_ff, pt_in;
   logic [2:0] k_ff, k_in, pk_ff, pk_in;
   logic pend_ff, pend_in;
   logic signed [AB-1:0] acc_ff [4];
   logic signed [AB-1:0] acc_in [4];
   logic q_ff, q_in;
   logic signed [SCORE_BITS-1:0] s_ff [2];
   logic signed [SCORE_BITS-1:0] s_in [2];
   logic signed [SCORE_BITS-1:0] ns0_ff, ns0_in;
   logic bp0_ff, bp0_in, tag_ff, tag_in, sub_ff, sub_in;
   logic [WA-1:0] clr_ff, clr_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_tag_ff, rsp_tag_in;
   logic [5:0] rsp_pos_ff, rsp_pos_in;
   logic rsp_last_ff, rsp_last_in, rsp_ovf_ff, rsp_ovf_in;
   logic [6:0] vocab_ff, vocab_in;
   logic train_ff, train_in;

   // memory ports
   logic tok_we;
   logic [AW-1:0] tok_waddr, tok_raddr;
   logic [TOK_W:0] tok_wdata, tok_rdata;
   logic w_we;
   logic [WA-1:0] w_waddr, w_raddr;
   logic [WEIGHT_BITS-1:0] w_wdata, w_rdata;
   logic bp_we;
   logic [AW-1:0] bp_waddr, bp_raddr;
   logic [1:0] bp_wdata, bp_rdata;
   logic seq_we;
   logic [AW-1:0] seq_waddr, seq_raddr;
   logic seq_wdata, seq_rdata;

   // datapath helpers
   logic [VB-1:0] veff;
   pvs_win_type win;
   logic [FB-1:0] feat;
   logic [2:0] fsel;
   logic [LW-1:0] j_next, j_prev;
   logic last_j, mismatch;
   logic req_fire, cfg_wr;
   logic signed [SW-1:0] sum0, sum1;
   logic signed [SCORE_BITS-1:0] c0, c1, cq;
   logic bq;
   logic signed [WW-1:0] wsum;

   assign req_fire = req_valid && req_ready;
   assign cfg_wr   = psel && penable && pwrite && pready;
   assign pready   = 1'b1;
   assign j_next   = j_ff + LW'(1);
   assign j_prev   = j_ff - LW'(1);
   assign last_j   = (j_next == len_ff);
   assign mismatch = (gcur_ff != p_ff);

   // effective dictionary size
   always_comb begin
      if (vocab_ff == 7'd0) begin
         veff = VB'(1);
      end else if (9'(vocab_ff) > 9'(VOCAB)) begin
         veff = VB'(VOCAB);
      end else begin
         veff = VB'(vocab_ff);
      end
   end

   // token window
   always_comb begin
      win.prev     = wprev_ff;
      win.cur      = wcur_ff;
      win.nxt      = wnxt_ff;
      win.has_prev = (j_ff != '0);
      win.has_next = (j_next < len_ff);
   end

   assign fsel = k_ff;

   pvs_feat #(.VOCAB(VOCAB)) u_feat (
      .win   (win),
      .vocab (veff),
      .sel   (fsel),
      .feat  (feat)
   );

   pvs_ram #(.WIDTH(TOK_W+1), .DEPTH(MAX_LEN)) u_tok_ram (
      .clock(clock), .wr_en(tok_we), .wr_addr(tok_waddr), .wr_data(tok_wdata),
      .rd_addr(tok_raddr), .rd_data(tok_rdata)
   );

   pvs_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(4 << FB)) u_weight_ram (
      .clock(clock), .wr_en(w_we), .wr_addr(w_waddr), .wr_data(w_wdata),
      .rd_addr(w_raddr), .rd_data(w_rdata)
   );

   pvs_ram #(.WIDTH(2), .DEPTH(MAX_LEN)) u_bp_ram (
      .clock(clock), .wr_en(bp_we), .wr_addr(bp_waddr), .wr_data(bp_wdata),
      .rd_addr(bp_raddr), .rd_data(bp_rdata)
   );

   pvs_ram #(.WIDTH(1), .DEPTH(MAX_LEN)) u_seq_ram (
      .clock(clock), .wr_en(seq_we), .wr_addr(seq_waddr), .wr_data(seq_wdata),
      .rd_addr(seq_raddr), .rd_data(seq_rdata)
   );

   // shared compare unit: both predecessors of tag q
   always_comb begin
      sum0 = SW'(acc_ff[{1'b0, q_ff}]);
      sum1 = SW'(s_ff[1]) + SW'(acc_ff[{1'b1, q_ff}]);
      if (j_ff != '0) begin
         sum0 = SW'(s_ff[0]) + SW'(acc_ff[{1'b0, q_ff}]);
      end
      c0 = sat_score(sum0);
      c1 = sat_score(sum1);
      if ((j_ff == '0) || (c0 > c1)) begin
         cq = c0;
         bq = 1'b0;
      end else begin
         cq = c1;
         bq = 1'b1;
      end
   end

   // weight update with saturation
   always_comb begin
      wsum = WW'(signed'(w_rdata)) + (sub_ff ? -WW'(1) : WW'(1));
      if (wsum > WMAX) wsum = WMAX;
      if (wsum < WMIN) wsum = WMIN;
   end

   // csr read
   always_comb begin
      case (paddr[2])
         CSR_VOCAB: prdata = 32'(vocab_ff);
         CSR_TRAIN: prdata = 32'(train_ff);
         default:   prdata = '0;
      endcase
   end

   // next state and datapath control
   always_comb begin
      state_in = state_ff;
      j_in = j_ff; len_in = len_ff; ovf_in = ovf_ff; phase_in = phase_ff;
      wprev_in = wprev_ff; wcur_in = wcur_ff; wnxt_in = wnxt_ff;
      gcur_in = gcur_ff; gnxt_in = gnxt_ff; p_in = p_ff;
      gprev_in = gprev_ff; pprev_in = pprev_ff;
      t_in = t_ff; k_in = k_ff; pt_in = t_ff; pk_in = k_ff;
      pend_in = 1'b0;
      acc_in = acc_ff;
      q_in = q_ff; s_in = s_ff; ns0_in = ns0_ff; bp0_in = bp0_ff;
      tag_in = tag_ff; sub_in = sub_ff; clr_in = clr_ff;
      rsp_valid_in = rsp_valid_ff; rsp_tag_in = rsp_tag_ff; rsp_pos_in = rsp_pos_ff;
      rsp_last_in = rsp_last_ff; rsp_ovf_in = rsp_ovf_ff;
      vocab_in = vocab_ff; train_in = train_ff;

      tok_we = 1'b0; tok_waddr = len_ff[AW-1:0];
      tok_wdata = {req_gold_boundary, req_token_id};
      tok_raddr = j_next[AW-1:0];
      w_we = 1'b0; w_waddr = {sub_ff ? {pprev_ff, p_ff} : {gprev_ff, gcur_ff}, feat};
      w_wdata = wsum[WEIGHT_BITS-1:0];
      w_raddr = {t_ff, feat};
      bp_we = 1'b0; bp_waddr = j_ff[AW-1:0]; bp_wdata = {bq, bp0_ff};
      bp_raddr = j_ff[AW-1:0];
      seq_we = 1'b0; seq_waddr = j_ff[AW-1:0]; seq_wdata = tag_ff;
      seq_raddr = j_ff[AW-1:0];

      // accumulate arriving weight reads
      if (pend_ff) begin
         if (pk_ff == 3'd0) begin
            acc_in[pt_ff] = AB'(signed'(w_rdata));
         end else begin
            acc_in[pt_ff] = acc_ff[pt_ff] + AB'(signed'(w_rdata));
         end
      end

      // csr writes
      if (cfg_wr) begin
         case (paddr[2])
            CSR_VOCAB: vocab_in = pwdata[6:0];
            CSR_TRAIN: train_in = pwdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            w_we = 1'b1;
            w_waddr = clr_ff;
            w_wdata = '0;
            clr_in = clr_ff + WA'(1);
            if (clr_ff == {WA{1'b1}}) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (len_ff < LW'(MAX_LEN)) begin
                  tok_we = 1'b1;
                  len_in = len_ff + LW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_end_of_sentence) begin
                  phase_in = 1'b0;
                  state_in = ST_PRIME;
               end
            end
         end
         ST_PRIME: begin
            j_in = '0;
            tok_raddr = '0;
            gprev_in = 1'b0;
            pprev_in = 1'b0;
            state_in = ST_PRIME_W;
         end
         ST_PRIME_W: begin
            wnxt_in = tok_rdata[TOK_W-1:0];
            gnxt_in = tok_rdata[TOK_W];
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_FETCH_W;
         end
         ST_FETCH_W: begin
            wprev_in = wcur_ff;
            wcur_in = wnxt_ff;
            wnxt_in = tok_rdata[TOK_W-1:0];
            gcur_in = gnxt_ff;
            gnxt_in = tok_rdata[TOK_W];
            p_in = seq_rdata;
            t_in = 2'd0;
            k_in = 3'd0;
            state_in = phase_ff ? ST_TR_CHK : ST_WRD;
         end
         ST_WRD: begin
            pend_in = 1'b1;
            if (k_ff == FEAT_LAST) begin
               k_in = 3'd0;
               t_in = t_ff + 2'd1;
               if (t_ff == 2'd3) state_in = ST_WLAST;
            end else begin
               k_in = k_ff + 3'd1;
            end
         end
         ST_WLAST: begin
            q_in = 1'b0;
            state_in = ST_COMB;
         end
         ST_COMB: begin
            if (!q_ff) begin
               ns0_in = cq;
               bp0_in = bq;
               q_in = 1'b1;
            end else begin
               bp_we = 1'b1;
               s_in[0] = ns0_ff;
               s_in[1] = cq;
               if (last_j) begin
                  tag_in = (ns0_ff >= cq) ? 1'b0 : 1'b1;
                  state_in = ST_BT_RD;
               end else begin
                  j_in = j_next;
                  state_in = ST_FETCH;
               end
            end
         end
         ST_BT_RD: begin
            state_in = ST_BT_WR;
         end
         ST_BT_WR: begin
            seq_we = 1'b1;
            tag_in = bp_rdata[tag_ff];
            if (j_ff == '0) begin
               state_in = ST_EM_RD;
            end else begin
               j_in = j_prev;
               state_in = ST_BT_RD;
            end
         end
         ST_EM_RD: begin
            state_in = ST_EM_LD;
         end
         ST_EM_LD: begin
            rsp_valid_in = 1'b1;
            rsp_tag_in = seq_rdata;
            rsp_pos_in = 6'(j_ff);
            rsp_last_in = last_j;
            rsp_ovf_in = ovf_ff;
            state_in = ST_EM_HOLD;
         end
         ST_EM_HOLD: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (!last_j) begin
                  j_in = j_next;
                  state_in = ST_EM_RD;
               end else if (train_ff) begin
                  phase_in = 1'b1;
                  state_in = ST_PRIME;
               end else begin
                  len_in = '0;
                  ovf_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_TR_CHK: begin
            sub_in = 1'b0;
            if (mismatch) begin
               state_in = ST_TR_RD;
            end else begin
               gprev_in = gcur_ff;
               pprev_in = p_ff;
               if (last_j) begin
                  len_in = '0;
                  ovf_in = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  j_in = j_next;
                  state_in = ST_FETCH;
               end
            end
         end
         ST_TR_RD: begin
            w_raddr = w_waddr;
            state_in = ST_TR_WR;
         end
         ST_TR_WR: begin
            w_we = 1'b1;
            if (!sub_ff) begin
               sub_in = 1'b1;
               state_in = ST_TR_RD;
            end else begin
               sub_in = 1'b0;
               if (k_ff == FEAT_LAST) begin
                  k_in = 3'd0;
                  gprev_in = gcur_ff;
                  pprev_in = p_ff;
                  if (last_j) begin
                     len_in = '0;
                     ovf_in = 1'b0;
                     state_in = ST_IDLE;
                  end else begin
                     j_in = j_next;
                     state_in = ST_FETCH;
                  end
               end else begin
                  k_in = k_ff + 3'd1;
                  state_in = ST_TR_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         len_ff <= '0;
         ovf_ff <= 1'b0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vocab_ff <= VOCAB_RESET;
         train_ff <= 1'b0;
         s_ff[0] <= '0;
         s_ff[1] <= '0;
      end else begin
         clr_ff <= clr_in;
         len_ff <= len_in;
         ovf_ff <= ovf_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         vocab_ff <= vocab_in;
         train_ff <= train_in;
         s_ff <= s_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      j_ff <= j_in; phase_ff <= phase_in;
      wprev_ff <= wprev_in; wcur_ff <= wcur_in; wnxt_ff <= wnxt_in;
      gcur_ff <= gcur_in; gnxt_ff <= gnxt_in; p_ff <= p_in;
      gprev_ff <= gprev_in; pprev_ff <= pprev_in;
      t_ff <= t_in; k_ff <= k_in; pt_ff <= pt_in; pk_ff <= pk_in;
      acc_ff <= acc_in;
      q_ff <= q_in; ns0_ff <= ns0_in; bp0_ff <= bp0_in;
      tag_ff <= tag_in; sub_ff <= sub_in;
      rsp_tag_ff <= rsp_tag_in; rsp_pos_ff <= rsp_pos_in;
      rsp_last_ff <= rsp_last_in; rsp_ovf_ff <= rsp_ovf_in;
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_boundary_tag = rsp_tag_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_last_of_run  = rsp_last_ff;
   assign rsp_overflow     = rsp_ovf_ff;

endmodule
